// ===== rtl/core/table_driven_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the table driven tokenizer unit
// Concurrent checks sampled on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_TOKENIZER_UNIT_MACROS_SVH
`define TABLE_DRIVEN_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication
`define TDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants of the table driven tokenizer unit.
// ----------------------------------------------------------------------------
package tdt_pkg;

    // Width of the integer value field on the result port
    localparam int unsigned INT_W          = 31;
    // Default width of the decimal accumulator
    localparam int unsigned VALUE_BITS_DEF = 31;
    // Result queue depth, a power of two of at least 4
    localparam int unsigned RQ_DEPTH       = 4;
    localparam int unsigned RQ_PW          = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW          = $clog2(RQ_DEPTH + 1);

    typedef enum logic {
        KIND_CHAR  = 1'b0,
        KIND_TOKEN = 1'b1
    } t_rkind;

    typedef enum logic [2:0] {
        TK_ILLEGAL = 3'd0,
        TK_WORD    = 3'd1,
        TK_INT     = 3'd2,
        TK_SPECIAL = 3'd3,
        TK_LITERAL = 3'd4
    } t_tok;

    typedef struct packed {
        t_rkind           kind;
        logic [7:0]       out_char;
        t_tok             token_kind;
        logic [INT_W-1:0] int_value;
        logic             sat;
        logic             ended;
        logic             last;
    } t_result;

    // Up to two result beats produced by one scanned character
    typedef struct packed {
        logic [1:0]        n;
        t_result [1:0]     res;
    } t_scan_out;

endpackage

// ===== rtl/core/tdt_scan.sv =====
// ----------------------------------------------------------------------------
// tdt_scan
// Character classifier, scanner state table and decimal accumulator.
// ----------------------------------------------------------------------------
module tdt_scan import tdt_pkg::*; #(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output t_scan_out  o_out
);

    typedef enum logic [6:0] {
        ST_START = 7'b0000001,
        ST_WORD  = 7'b0000010,
        ST_INT   = 7'b0000100,
        ST_SPEC  = 7'b0001000,
        ST_QOPEN = 7'b0010000,
        ST_TAIL  = 7'b0100000,
        ST_LIT   = 7'b1000000
    } t_scan_state;

    typedef enum logic [2:0] {
        CLS_END     = 3'd0,
        CLS_QUOTE   = 3'd1,
        CLS_LETTER  = 3'd2,
        CLS_DIGIT   = 3'd3,
        CLS_DELIM   = 3'd4,
        CLS_SPECIAL = 3'd5
    } t_cls;

    typedef struct packed {
        logic        done;
        t_scan_state nxt;
    } t_step;

    localparam int unsigned AW = VALUE_BITS + 4;

    function automatic t_step next_of(t_scan_state s, t_cls c);
        t_step r;
        r.done = 1'b1;
        r.nxt  = ST_START;
        unique case (s)
            ST_WORD: begin
                if (c == CLS_LETTER) begin r.done = 1'b0; r.nxt = ST_WORD; end
                else if (c == CLS_DELIM) begin r.done = 1'b0; r.nxt = ST_TAIL; end
            end
            ST_INT: begin
                if (c == CLS_DIGIT) begin r.done = 1'b0; r.nxt = ST_INT; end
                else if (c == CLS_DELIM) begin r.done = 1'b0; r.nxt = ST_TAIL; end
            end
            ST_SPEC: begin
                if (c == CLS_SPECIAL) begin r.done = 1'b0; r.nxt = ST_SPEC; end
                else if (c == CLS_DELIM) begin r.done = 1'b0; r.nxt = ST_TAIL; end
            end
            ST_TAIL: begin
                if (c == CLS_DELIM) begin r.done = 1'b0; r.nxt = ST_TAIL; end
            end
            ST_QOPEN, ST_LIT: begin
                if (c == CLS_QUOTE) begin r.done = 1'b0; r.nxt = ST_TAIL; end
                else if (c != CLS_END) begin r.done = 1'b0; r.nxt = ST_LIT; end
            end
            default: begin
                // start state
                r.done = 1'b0;
                case (c)
                    CLS_END:     r.done = 1'b1;
                    CLS_QUOTE:   r.nxt  = ST_QOPEN;
                    CLS_LETTER:  r.nxt  = ST_WORD;
                    CLS_DIGIT:   r.nxt  = ST_INT;
                    CLS_SPECIAL: r.nxt  = ST_SPEC;
                    default:     r.nxt  = ST_START;
                endcase
            end
        endcase
        return r;
    endfunction

    t_scan_state           r_state, n_state;
    t_tok                  r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_sat, n_sat;

    t_cls                  cls;
    t_step                 tr, ent;
    t_scan_state           enter_st;
    logic                  done, do_enter, char_emit;
    t_tok                  base_kind;
    logic [VALUE_BITS-1:0] base_acc;
    logic                  base_sat;
    logic [AW-1:0]         acc_x10, acc_sum;
    logic                  acc_over;
    t_result               tok_res, chr_res;

    always_comb begin
        if (i_end) begin
            cls = CLS_END;
        end else if (i_char == 8'h22 || i_char == 8'h27) begin
            cls = CLS_QUOTE;
        end else if ((i_char >= 8'h41 && i_char <= 8'h5A) ||
                     (i_char >= 8'h61 && i_char <= 8'h7A)) begin
            cls = CLS_LETTER;
        end else if (i_char >= 8'h30 && i_char <= 8'h39) begin
            cls = CLS_DIGIT;
        end else if (i_char == 8'h20 || i_char == 8'h2C) begin
            cls = CLS_DELIM;
        end else begin
            cls = CLS_SPECIAL;
        end
    end

    always_comb begin
        tr        = next_of(r_state, cls);
        ent       = next_of(ST_START, cls);
        done      = tr.done;
        enter_st  = done ? ent.nxt : tr.nxt;
        // an end mark is not scanned again after the token closes
        do_enter  = !(done && i_end);
        base_kind = done ? TK_ILLEGAL : r_kind;
        base_acc  = done ? '0 : r_acc;
        base_sat  = done ? 1'b0 : r_sat;

        acc_x10  = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1);
        acc_sum  = acc_x10 + AW'(i_char[3:0]);
        acc_over = acc_sum > {4'b0, {VALUE_BITS{1'b1}}};

        n_state   = do_enter ? enter_st : ST_START;
        n_kind    = base_kind;
        n_acc     = base_acc;
        n_sat     = base_sat;
        char_emit = 1'b0;
        if (do_enter) begin
            unique case (enter_st)
                ST_WORD: begin
                    n_kind    = TK_WORD;
                    char_emit = 1'b1;
                end
                ST_INT: begin
                    n_kind = TK_INT;
                    if (acc_over) begin
                        n_acc = {VALUE_BITS{1'b1}};
                        n_sat = 1'b1;
                    end else begin
                        n_acc = acc_sum[VALUE_BITS-1:0];
                    end
                end
                ST_SPEC: begin
                    n_kind    = TK_SPECIAL;
                    char_emit = 1'b1;
                end
                ST_LIT: begin
                    n_kind    = TK_LITERAL;
                    char_emit = 1'b1;
                end
                default: ;
            endcase
        end

        tok_res.kind       = KIND_TOKEN;
        tok_res.out_char   = 8'd0;
        tok_res.token_kind = r_kind;
        tok_res.int_value  = INT_W'(r_acc);
        tok_res.sat        = r_sat;
        tok_res.ended      = i_end;
        tok_res.last       = !char_emit;

        chr_res.kind       = KIND_CHAR;
        chr_res.out_char   = i_char;
        chr_res.token_kind = TK_ILLEGAL;
        chr_res.int_value  = '0;
        chr_res.sat        = 1'b0;
        chr_res.ended      = 1'b0;
        chr_res.last       = 1'b1;

        o_out.n      = {1'b0, done} + {1'b0, char_emit};
        o_out.res[0] = done ? tok_res : chr_res;
        o_out.res[1] = chr_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_kind  <= TK_ILLEGAL;
            r_acc   <= '0;
            r_sat   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
        end
    end

endmodule

// ===== rtl/core/tdt_rq.sv =====
// ----------------------------------------------------------------------------
// tdt_rq
// Result queue: takes up to two beats per cycle, hands out one.
// ----------------------------------------------------------------------------
module tdt_rq import tdt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_scan_out        i_data,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output logic [RQ_CW-1:0] o_level,
    output t_result          o_head
);

    t_result [RQ_DEPTH-1:0] r_mem;
    logic [RQ_PW-1:0]       r_wp, r_rp;
    logic [RQ_CW-1:0]       r_cnt, n_cnt;
    logic [1:0]             push_n;
    logic [RQ_PW-1:0]       wp_next;

    assign push_n  = i_push ? i_data.n : 2'd0;
    assign wp_next = RQ_PW'(r_wp + 1'b1);
    assign n_cnt   = r_cnt + RQ_CW'(push_n) - RQ_CW'(i_pop);

    // room for a worst-case item of two beats
    assign o_room  = r_cnt <= RQ_CW'(RQ_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_level = r_cnt;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_data.res[0];
        end
        if (push_n == 2'd2) begin
            r_mem[wp_next] <= i_data.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= RQ_PW'(r_wp + RQ_PW'(push_n));
            if (i_pop) begin
                r_rp <= RQ_PW'(r_rp + 1'b1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/table_driven_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// table_driven_tokenizer_unit
// Character-at-a-time lexer: words, integers, special runs and quoted
// literals, with a character beat per appended character and a token beat
// per completed token.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   input   | in        | i_valid / o_stall  | i_char_code, i_end_mark
//   result  | out       | o_valid / i_stall  | o_kind .. o_last (7 fields)
//
// An accepted beat is held in the input register and scanned from there once
// the queue has room for two results; its results enter the queue at the end of
// that cycle and are visible on the result port in the cycle after.
// One input beat per cycle is sustained, while the result side does not stall,
// as long as each character yields at most one result; a character that closes
// one token and opens another yields two beats, which the single read port of
// the result queue then hands out one at a time.
// Reset is synchronous on i_rst_n and needs no clearing pass: the scanner
// returns to its start state and the queue empties.
// A stall on the result side backs up through the four-entry queue into the
// input register, which raises o_stall only once it cannot advance.
// ----------------------------------------------------------------------------
module table_driven_tokenizer_unit import tdt_pkg::*; #(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_char_code,
    input  logic             i_end_mark,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_kind,
    output logic [7:0]       o_out_char,
    output logic [2:0]       o_token_kind,
    output logic [INT_W-1:0] o_int_value,
    output logic             o_value_saturated,
    output logic             o_input_ended,
    output logic             o_last
);

`include "table_driven_tokenizer_unit_macros.svh"

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_end;

    logic             in_take;
    logic             adv;
    logic             q_room;
    logic             q_pop;
    logic [RQ_CW-1:0] q_level;
    t_scan_out        scan_out;
    t_result          head;

    // advance the held beat only when the queue can swallow two results
    assign adv     = r_in_vld && q_room;
    assign o_stall = r_in_vld && !q_room;
    assign in_take = i_valid && !o_stall;
    assign q_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_take || (r_in_vld && !adv);
        end
    end

    // payload: load on a new beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_code;
            r_in_end  <= i_end_mark;
        end
    end

    tdt_scan #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_char  (r_in_char),
        .i_end   (r_in_end),
        .o_out   (scan_out)
    );

    tdt_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_data  (scan_out),
        .i_pop   (q_pop),
        .o_room  (q_room),
        .o_valid (o_valid),
        .o_level (q_level),
        .o_head  (head)
    );

    // drive the result fields straight from the queue head
    assign o_kind            = head.kind;
    assign o_out_char        = head.out_char;
    assign o_token_kind      = head.token_kind;
    assign o_int_value       = head.int_value;
    assign o_value_saturated = head.sat;
    assign o_input_ended     = head.ended;
    assign o_last            = head.last;

    // ---- checks ----
    `TDT_ASSERT_NOW(a_room_on_adv, adv, q_level <= RQ_CW'(RQ_DEPTH - 2), "queue overrun on advance")
    `TDT_ASSERT_NEXT(a_end_yields_beat, adv && r_in_end, o_valid, "end mark produced no result")
    `TDT_ASSERT_NOW(a_end_is_last, o_valid && o_kind == KIND_TOKEN && o_input_ended, o_last, "end-of-input token not last")
    `TDT_ASSERT_NOW(a_char_clean, o_valid && o_kind == KIND_CHAR, o_token_kind == TK_ILLEGAL && o_int_value == '0 && !o_input_ended, "character beat carries token fields")

endmodule
